[rtl/twea_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// twea_pkg
// Shared types and constants for the tracking window edge adapter.
// ----------------------------------------------------------------------------
package twea_pkg;

  localparam int PIXEL_W  = 8;
  localparam int COLS_W   = 10;
  localparam int ROWS_W   = 9;
  localparam int SUM_W    = 18;
  localparam int NUM_SUMS = 12;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 18;
  localparam int QUEUE_DEPTH = 4;

  localparam int DEF_MAX_STROBE_COLS = 1024;
  localparam int DEF_MAX_STROBE_ROWS = 512;

  // Sum slots: three per border group, in ascending row or column order.
  localparam int TOP_BASE    = 0;
  localparam int BOTTOM_BASE = 3;
  localparam int LEFT_BASE   = 6;
  localparam int RIGHT_BASE  = 9;

  localparam logic [CFG_IDX_W-1:0] REG_MIN_COLS  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_MAX_COLS  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_MIN_ROWS  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_MAX_ROWS  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_THRESHOLD = 3'd4;

  localparam logic [COLS_W-1:0] RST_MIN_COLS  = 10'd4;
  localparam logic [COLS_W-1:0] RST_MAX_COLS  = 10'd128;
  localparam logic [ROWS_W-1:0] RST_MIN_ROWS  = 9'd4;
  localparam logic [ROWS_W-1:0] RST_MAX_ROWS  = 9'd96;
  localparam logic [SUM_W-1:0]  RST_THRESHOLD = 18'd510;

  localparam logic [SUM_W-1:0] SUM_MAX = {SUM_W{1'b1}};

  typedef struct packed {
    logic [COLS_W-1:0] min_cols;
    logic [COLS_W-1:0] max_cols;
    logic [ROWS_W-1:0] min_rows;
    logic [ROWS_W-1:0] max_rows;
    logic [SUM_W-1:0]  threshold;
  } cfg_t;

  typedef struct packed {
    logic [COLS_W-1:0] scols;
    logic [ROWS_W-1:0] srows;
    logic [COLS_W-1:0] x;
    logic [ROWS_W-1:0] y;
    logic [COLS_W-1:0] cols;
    logic [ROWS_W-1:0] rows;
  } hdr_t;

  typedef struct packed {
    logic [PIXEL_W-1:0]  pixel;
    logic [NUM_SUMS-1:0] mask;
    logic                first;
    logic                last;
    hdr_t                hdr;
  } item_t;

endpackage
`default_nettype wire

[rtl/twea_fifo.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// twea_fifo
// Short queue of classified items between the front and the back.
// ----------------------------------------------------------------------------
module twea_fifo (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            push_valid,
  output logic                 push_ready,
  input  wire twea_pkg::item_t push_item,
  output logic                 pop_valid,
  input  wire logic            pop_ready,
  output twea_pkg::item_t      pop_item
);

  localparam int DEPTH = twea_pkg::QUEUE_DEPTH;
  localparam int PTR_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);

  twea_pkg::item_t  mem [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;
  logic             do_push;
  logic             do_pop;

  assign push_ready = (count != CNT_W'(DEPTH));
  assign pop_valid  = (count != '0);
  assign pop_item   = mem[rd_ptr];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr] <= push_item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule
`default_nettype wire

[rtl/twea_front.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// twea_front
// Tracks the raster position, latches the frame header and marks which of
// the twelve line sums each pixel feeds.
// ----------------------------------------------------------------------------
module twea_front #(
  parameter int MAX_STROBE_COLS = twea_pkg::DEF_MAX_STROBE_COLS,
  parameter int MAX_STROBE_ROWS = twea_pkg::DEF_MAX_STROBE_ROWS
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          in_valid,
  output logic                               in_ready,
  input  wire logic [twea_pkg::PIXEL_W-1:0]  pixel,
  input  wire logic                          first,
  input  wire logic                          last,
  input  wire logic [twea_pkg::COLS_W-1:0]   strobe_cols,
  input  wire logic [twea_pkg::ROWS_W-1:0]   strobe_rows,
  input  wire logic [twea_pkg::COLS_W-1:0]   win_x,
  input  wire logic [twea_pkg::ROWS_W-1:0]   win_y,
  input  wire logic [twea_pkg::COLS_W-1:0]   win_cols,
  input  wire logic [twea_pkg::ROWS_W-1:0]   win_rows,
  output logic                               push_valid,
  input  wire logic                          push_ready,
  output twea_pkg::item_t                    push_item
);

  localparam int CW  = $clog2(MAX_STROBE_COLS);
  localparam int RW  = $clog2(MAX_STROBE_ROWS);
  localparam int CXW = ((CW > twea_pkg::COLS_W) ? CW : twea_pkg::COLS_W) + 2;
  localparam int RXW = ((RW > twea_pkg::ROWS_W) ? RW : twea_pkg::ROWS_W) + 2;

  logic [CW-1:0]  col_count;
  logic [CW-1:0]  col_next;
  logic [RW-1:0]  row_count;
  logic [RW-1:0]  row_next;
  twea_pkg::hdr_t hdr;
  twea_pkg::hdr_t hdr_next;
  logic [CXW-1:0] c_w;
  logic [RXW-1:0] r_w;
  logic [CXW-1:0] c_inc;
  logic           col_wrap;
  logic           in_strobe;
  logic           col_span;
  logic           row_span;
  logic [twea_pkg::NUM_SUMS-1:0] mask;
  logic           accept;

  assign in_ready   = push_ready;
  assign push_valid = in_valid;
  assign accept     = in_valid && push_ready;

  always_comb begin
    // A first pixel restarts the frame at line 0, column 0 with a new header.
    if (first) begin
      hdr_next = '{scols: strobe_cols, srows: strobe_rows, x: win_x, y: win_y,
                   cols: win_cols, rows: win_rows};
      c_w = '0;
      r_w = '0;
    end else begin
      hdr_next = hdr;
      c_w = CXW'(col_count);
      r_w = RXW'(row_count);
    end

    in_strobe = (r_w < RXW'(hdr_next.srows)) && (c_w < CXW'(hdr_next.scols));
    col_span  = (c_w >= CXW'(hdr_next.x)) &&
                (c_w < CXW'(hdr_next.x) + CXW'(hdr_next.cols));
    row_span  = (r_w >= RXW'(hdr_next.y)) &&
                (r_w < RXW'(hdr_next.y) + RXW'(hdr_next.rows));

    mask = '0;
    for (int g = 0; g < 3; g++) begin
      mask[twea_pkg::TOP_BASE + g] = in_strobe && col_span &&
        (r_w + 1'b1 == RXW'(hdr_next.y) + RXW'(g));
      mask[twea_pkg::BOTTOM_BASE + g] = in_strobe && col_span &&
        (r_w + 2'd2 == RXW'(hdr_next.y) + RXW'(hdr_next.rows) + RXW'(g));
      mask[twea_pkg::LEFT_BASE + g] = in_strobe && row_span &&
        (c_w + 1'b1 == CXW'(hdr_next.x) + CXW'(g));
      mask[twea_pkg::RIGHT_BASE + g] = in_strobe && row_span &&
        (c_w + 2'd2 == CXW'(hdr_next.x) + CXW'(hdr_next.cols) + CXW'(g));
    end

    c_inc    = c_w + 1'b1;
    col_wrap = (c_inc >= CXW'(hdr_next.scols)) || (c_inc >= CXW'(MAX_STROBE_COLS));
    if (col_wrap) begin
      col_next = '0;
      // The line count holds at its top value.
      if (r_w[RW-1:0] != RW'(MAX_STROBE_ROWS - 1)) begin
        row_next = r_w[RW-1:0] + 1'b1;
      end else begin
        row_next = r_w[RW-1:0];
      end
    end else begin
      col_next = c_inc[CW-1:0];
      row_next = r_w[RW-1:0];
    end

    push_item = '{pixel: pixel, mask: mask, first: first, last: last, hdr: hdr_next};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      col_count <= '0;
      row_count <= '0;
      hdr       <= '0;
    end else if (accept) begin
      col_count <= col_next;
      row_count <= row_next;
      hdr       <= hdr_next;
    end
  end

endmodule
`default_nettype wire

[rtl/twea_back.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// twea_back
// Accumulates the twelve line sums and, after the final pixel of a frame,
// applies the grow and shrink rules into the result register.
// ----------------------------------------------------------------------------
module twea_back (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire twea_pkg::cfg_t                cfg,
  input  wire logic                          pop_valid,
  output logic                               pop_ready,
  input  wire twea_pkg::item_t               pop_item,
  output logic                               out_valid,
  input  wire logic                          out_ready,
  output logic [twea_pkg::COLS_W-1:0]        new_x,
  output logic [twea_pkg::ROWS_W-1:0]        new_y,
  output logic [twea_pkg::COLS_W-1:0]        new_cols,
  output logic [twea_pkg::ROWS_W-1:0]        new_rows,
  output logic                               moved
);

  localparam int AW = 13;
  localparam logic signed [AW-1:0] ONE = AW'(1);

  logic [twea_pkg::SUM_W-1:0] sums      [twea_pkg::NUM_SUMS];
  logic [twea_pkg::SUM_W-1:0] sums_next [twea_pkg::NUM_SUMS];
  logic                       dec_pending;
  twea_pkg::hdr_t             dec_hdr;
  logic                       do_pop;
  logic                       do_dec;
  logic [twea_pkg::NUM_SUMS-1:0] above;
  logic                       top_gt, bot_gt, left_gt, right_gt;
  logic                       top_le, bot_le, left_le, right_le;
  logic signed [AW-1:0]       xv, yv, cv, rv;
  logic                       mv;

  // The decision reads the registered sums, so the next item may be summed
  // in the same cycle as long as the decision itself can load its result.
  assign pop_ready = !dec_pending || !out_valid || out_ready;
  assign do_pop    = pop_valid && pop_ready;
  assign do_dec    = dec_pending && (!out_valid || out_ready);

  always_comb begin
    logic [twea_pkg::SUM_W-1:0] base;
    logic [twea_pkg::SUM_W:0]   total;
    for (int i = 0; i < twea_pkg::NUM_SUMS; i++) begin
      base  = pop_item.first ? '0 : sums[i];
      total = {1'b0, base} + (twea_pkg::SUM_W + 1)'(pop_item.pixel);
      if (!pop_item.mask[i]) begin
        sums_next[i] = base;
      end else if (total > {1'b0, twea_pkg::SUM_MAX}) begin
        sums_next[i] = twea_pkg::SUM_MAX;
      end else begin
        sums_next[i] = total[twea_pkg::SUM_W-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < twea_pkg::NUM_SUMS; i++) begin
        sums[i] <= '0;
      end
    end else if (do_pop) begin
      for (int i = 0; i < twea_pkg::NUM_SUMS; i++) begin
        sums[i] <= sums_next[i];
      end
    end
  end

  // A group grows when any of its sums is above the threshold and shrinks
  // when any is at or below it.
  always_comb begin
    for (int i = 0; i < twea_pkg::NUM_SUMS; i++) begin
      above[i] = sums[i] > cfg.threshold;
    end
    top_gt   = |above[twea_pkg::TOP_BASE    +: 3];
    bot_gt   = |above[twea_pkg::BOTTOM_BASE +: 3];
    left_gt  = |above[twea_pkg::LEFT_BASE   +: 3];
    right_gt = |above[twea_pkg::RIGHT_BASE  +: 3];
    top_le   = !(&above[twea_pkg::TOP_BASE    +: 3]);
    bot_le   = !(&above[twea_pkg::BOTTOM_BASE +: 3]);
    left_le  = !(&above[twea_pkg::LEFT_BASE   +: 3]);
    right_le = !(&above[twea_pkg::RIGHT_BASE  +: 3]);
  end

  always_comb begin
    xv = $signed(AW'(dec_hdr.x));
    yv = $signed(AW'(dec_hdr.y));
    cv = $signed(AW'(dec_hdr.cols));
    rv = $signed(AW'(dec_hdr.rows));
    mv = 1'b0;

    // Rows and columns form two independent chains, each in rule order.
    if (rv < $signed(AW'(cfg.max_rows)) && bot_gt &&
        (yv + rv) < $signed(AW'(dec_hdr.srows))) begin
      rv = rv + ONE;
    end
    if (rv < $signed(AW'(cfg.max_rows)) && top_gt && yv > 0) begin
      rv = rv + ONE;
      yv = yv - ONE;
      mv = 1'b1;
    end
    if (rv > $signed(AW'(cfg.min_rows)) && bot_le) begin
      rv = rv - ONE;
      mv = 1'b1;
    end
    if (rv > $signed(AW'(cfg.min_rows)) && top_le) begin
      rv = rv - ONE;
      yv = yv + ONE;
      mv = 1'b1;
    end

    if (cv < $signed(AW'(cfg.max_cols)) && right_gt &&
        (xv + cv) < $signed(AW'(dec_hdr.scols))) begin
      cv = cv + ONE;
    end
    if (cv < $signed(AW'(cfg.max_cols)) && left_gt && xv > 0) begin
      cv = cv + ONE;
      xv = xv - ONE;
      mv = 1'b1;
    end
    if (cv > $signed(AW'(cfg.min_cols)) && right_le) begin
      cv = cv - ONE;
      mv = 1'b1;
    end
    if (cv > $signed(AW'(cfg.min_cols)) && left_le) begin
      cv = cv - ONE;
      xv = xv + ONE;
      mv = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (do_pop && pop_item.last) begin
      dec_hdr <= pop_item.hdr;
    end
    if (do_dec) begin
      new_x    <= xv[twea_pkg::COLS_W-1:0];
      new_y    <= yv[twea_pkg::ROWS_W-1:0];
      new_cols <= cv[twea_pkg::COLS_W-1:0];
      new_rows <= rv[twea_pkg::ROWS_W-1:0];
      moved    <= mv;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      dec_pending <= 1'b0;
      out_valid   <= 1'b0;
    end else begin
      if (do_pop && pop_item.last) begin
        dec_pending <= 1'b1;
      end else if (do_dec) begin
        dec_pending <= 1'b0;
      end
      if (do_dec) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule
`default_nettype wire

[rtl/track_window_edge_adapt.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// track_window_edge_adapt
// Adapts a tracked rectangle to the edge energy along its borders in one
// strobe frame of edge pixels.
// ----------------------------------------------------------------------------
//  Channel  Signals                          Moves
//  in       in_valid / in_ready              one pixel item with frame header
//  out      out_valid / out_ready            one adjusted rectangle per frame
//  cfg      cfg_valid / cfg_ready, index     one register write
//
//  A pixel is taken every cycle while the four-entry queue has room; the
//  back part sums one pixel per cycle.
//  The decision runs once the final pixel has been summed, alongside the
//  next pixel, and waits while an earlier result waits on out_ready; the
//  back stalls only while a decided result waits on out_ready.
//  Reset clears the sums, position, header and handshake state; config
//  registers return to their reset values. cfg_ready is always high.
// ----------------------------------------------------------------------------
module track_window_edge_adapt #(
  parameter int MAX_STROBE_COLS = twea_pkg::DEF_MAX_STROBE_COLS,
  parameter int MAX_STROBE_ROWS = twea_pkg::DEF_MAX_STROBE_ROWS
) (
  input  wire logic                            clk,
  input  wire logic                            rst,
  input  wire logic                            in_valid,
  output logic                                 in_ready,
  input  wire logic [twea_pkg::PIXEL_W-1:0]    pixel,
  input  wire logic                            first,
  input  wire logic                            last,
  input  wire logic [twea_pkg::COLS_W-1:0]     strobe_cols,
  input  wire logic [twea_pkg::ROWS_W-1:0]     strobe_rows,
  input  wire logic [twea_pkg::COLS_W-1:0]     win_x,
  input  wire logic [twea_pkg::ROWS_W-1:0]     win_y,
  input  wire logic [twea_pkg::COLS_W-1:0]     win_cols,
  input  wire logic [twea_pkg::ROWS_W-1:0]     win_rows,
  output logic                                 out_valid,
  input  wire logic                            out_ready,
  output logic [twea_pkg::COLS_W-1:0]          new_x,
  output logic [twea_pkg::ROWS_W-1:0]          new_y,
  output logic [twea_pkg::COLS_W-1:0]          new_cols,
  output logic [twea_pkg::ROWS_W-1:0]          new_rows,
  output logic                                 moved,
  input  wire logic                            cfg_valid,
  output logic                                 cfg_ready,
  input  wire logic [twea_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [twea_pkg::CFG_DATA_W-1:0] cfg_data
);

  twea_pkg::cfg_t  cfg;
  logic            push_valid;
  logic            push_ready;
  twea_pkg::item_t push_item;
  logic            pop_valid;
  logic            pop_ready;
  twea_pkg::item_t pop_item;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.min_cols  <= twea_pkg::RST_MIN_COLS;
      cfg.max_cols  <= twea_pkg::RST_MAX_COLS;
      cfg.min_rows  <= twea_pkg::RST_MIN_ROWS;
      cfg.max_rows  <= twea_pkg::RST_MAX_ROWS;
      cfg.threshold <= twea_pkg::RST_THRESHOLD;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        twea_pkg::REG_MIN_COLS:  cfg.min_cols  <= cfg_data[twea_pkg::COLS_W-1:0];
        twea_pkg::REG_MAX_COLS:  cfg.max_cols  <= cfg_data[twea_pkg::COLS_W-1:0];
        twea_pkg::REG_MIN_ROWS:  cfg.min_rows  <= cfg_data[twea_pkg::ROWS_W-1:0];
        twea_pkg::REG_MAX_ROWS:  cfg.max_rows  <= cfg_data[twea_pkg::ROWS_W-1:0];
        twea_pkg::REG_THRESHOLD: cfg.threshold <= cfg_data[twea_pkg::SUM_W-1:0];
        default: begin
        end
      endcase
    end
  end

  twea_front #(
    .MAX_STROBE_COLS (MAX_STROBE_COLS),
    .MAX_STROBE_ROWS (MAX_STROBE_ROWS)
  ) u_front (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .pixel       (pixel),
    .first       (first),
    .last        (last),
    .strobe_cols (strobe_cols),
    .strobe_rows (strobe_rows),
    .win_x       (win_x),
    .win_y       (win_y),
    .win_cols    (win_cols),
    .win_rows    (win_rows),
    .push_valid  (push_valid),
    .push_ready  (push_ready),
    .push_item   (push_item)
  );

  twea_fifo u_fifo (
    .clk        (clk),
    .rst        (rst),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_item  (push_item),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready),
    .pop_item   (pop_item)
  );

  twea_back u_back (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .pop_valid (pop_valid),
    .pop_ready (pop_ready),
    .pop_item  (pop_item),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .new_x     (new_x),
    .new_y     (new_y),
    .new_cols  (new_cols),
    .new_rows  (new_rows),
    .moved     (moved)
  );

endmodule
`default_nettype wire
